@@ rtl/hrcd_pkg.sv @@
// ----------------------------------------------------------------------------
// hrcd_pkg
// Shared types, character constants and helper functions for the HTTP
// request completion detector.
// ----------------------------------------------------------------------------
package hrcd_pkg;

    // Default width of the length and body counters
    localparam int unsigned COUNT_WIDTH_DEF = 32;

    // Output field widths
    localparam int unsigned FIELD_WIDTH = 32;

    // Characters of interest
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_VT_CR = 8'h0D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_LOW_F = 8'h66;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_F  = 8'h46;
    localparam logic [7:0] CHAR_LOW_X = 8'h78;
    localparam logic [7:0] CHAR_UP_X  = 8'h58;
    localparam logic [7:0] CHAR_UP_C  = 8'h43;

    // Length of the "Content-Length" header name
    localparam logic [3:0] NAME_LEN = 4'd14;

    // Number base of the length field
    typedef enum logic [1:0] {
        BASE_DEC,
        BASE_OCT,
        BASE_HEX
    } base_t;

    // Input beat: one request byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_request;
    } req_beat_t;

    // Output beat: status after one byte
    typedef struct packed {
        logic                   complete;
        logic                   headers_done;
        logic                   length_present;
        logic [FIELD_WIDTH-1:0] declared_length;
        logic [FIELD_WIDTH-1:0] body_count;
    } status_beat_t;

    // Digit lookup result
    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } digit_t;

    // Character of the header name at a given position
    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = 8'h43; // C
            4'd1:    ch = 8'h6F; // o
            4'd2:    ch = 8'h6E; // n
            4'd3:    ch = 8'h74; // t
            4'd4:    ch = 8'h65; // e
            4'd5:    ch = 8'h6E; // n
            4'd6:    ch = 8'h74; // t
            4'd7:    ch = 8'h2D; // -
            4'd8:    ch = 8'h4C; // L
            4'd9:    ch = 8'h65; // e
            4'd10:   ch = 8'h6E; // n
            4'd11:   ch = 8'h67; // g
            4'd12:   ch = 8'h74; // t
            4'd13:   ch = 8'h68; // h
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Digit value of a character in a base; ok low when not a digit there
    function automatic digit_t digit_of(input logic [7:0] c, input base_t base);
        digit_t     d;
        logic [7:0] diff;
        d    = '0;
        diff = '0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            diff = c - CHAR_ZERO;
            d.ok = 1'b1;
        end else if (c >= CHAR_LOW_A && c <= CHAR_LOW_F) begin
            diff = c - CHAR_LOW_A + 8'd10;
            d.ok = 1'b1;
        end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
            diff = c - CHAR_UP_A + 8'd10;
            d.ok = 1'b1;
        end
        d.value = diff[3:0];
        unique case (base)
            BASE_HEX: ;
            BASE_OCT: if (d.value > 4'd7) d.ok = 1'b0;
            default:  if (d.value > 4'd9) d.ok = 1'b0;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/http_request_completion_detector.sv @@
// ----------------------------------------------------------------------------
// http_request_completion_detector
// Tracks one HTTP request byte by byte and reports after each byte whether
// the headers have ended and the Content-Length body has fully arrived.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                               Direction  Beat
//  byte      byte_valid / byte_ready / byte_beat     in       one request byte
//  status    status_valid / status_ready / status_beat out    status per byte
//
//  Each accepted byte produces its status beat in the next cycle; a byte can
//  be taken every cycle. The limit is the single parse step (name match,
//  header-end match and a shift-add accumulate) between the byte handshake
//  and the status register. Reset clears all parse state and the output
//  register. A stalled status beat holds; byte_ready then stays low until
//  the beat is taken, and rises again in the same cycle it is taken.
//
module http_request_completion_detector
    import hrcd_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         byte_valid,
    output logic         byte_ready,
    input  req_beat_t    byte_beat,
    output logic         status_valid,
    input  logic         status_ready,
    output status_beat_t status_beat
);

    localparam int unsigned ACC_WIDTH = COUNT_WIDTH + 4;

    typedef enum logic [2:0] {
        PH_COLON,
        PH_SPACE,
        PH_SIGN,
        PH_ZERO,
        PH_HEX,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    // State registers
    logic [1:0]             end_prog_reg,   end_prog_next;
    logic                   hdr_end_reg,    hdr_end_next;
    logic [3:0]             name_prog_reg,  name_prog_next;
    logic                   name_found_reg, name_found_next;
    phase_t                 phase_reg,      phase_next;
    base_t                  base_reg,       base_next;
    logic                   neg_reg,        neg_next;
    logic [COUNT_WIDTH-1:0] len_reg,        len_next;
    logic [COUNT_WIDTH-1:0] body_reg,       body_next;
    logic                   out_valid_reg,  out_valid_next;
    status_beat_t           out_beat_reg,   out_beat_next;

    // Current state, cleared when a byte opens a new request
    logic [1:0]             cur_end_prog;
    logic                   cur_hdr_end;
    logic [3:0]             cur_name_prog;
    logic                   cur_name_found;
    phase_t                 cur_phase;
    base_t                  cur_base;
    logic                   cur_neg;
    logic [COUNT_WIDTH-1:0] cur_len;
    logic [COUNT_WIDTH-1:0] cur_body;

    logic                   accept;
    logic [7:0]             c;
    digit_t                 dig;
    digit_t                 dig_hex;
    logic [ACC_WIDTH-1:0]   acc_ext;
    logic [ACC_WIDTH-1:0]   acc_prod;
    logic [ACC_WIDTH-1:0]   acc_sum;
    logic [COUNT_WIDTH-1:0] acc_val;
    logic [3:0]             name_idx;
    logic                   is_space;
    logic                   done;

    // Handshake: take a byte whenever the status register is free or draining
    assign accept     = byte_valid && byte_ready;
    assign byte_ready = !out_valid_reg || status_ready;
    assign c          = byte_beat.data_byte;

    // Select the starting state for this byte
    always_comb
    begin
        if (byte_beat.first_of_request) begin
            cur_end_prog   = '0;
            cur_hdr_end    = 1'b0;
            cur_name_prog  = '0;
            cur_name_found = 1'b0;
            cur_phase      = PH_COLON;
            cur_base       = BASE_DEC;
            cur_neg        = 1'b0;
            cur_len        = '0;
            cur_body       = '0;
        end else begin
            cur_end_prog   = end_prog_reg;
            cur_hdr_end    = hdr_end_reg;
            cur_name_prog  = name_prog_reg;
            cur_name_found = name_found_reg;
            cur_phase      = phase_reg;
            cur_base       = base_reg;
            cur_neg        = neg_reg;
            cur_len        = len_reg;
            cur_body       = body_reg;
        end
    end

    // Accumulate one digit with saturation
    always_comb
    begin
        dig     = digit_of(c, cur_base);
        dig_hex = digit_of(c, BASE_HEX);
        acc_ext = ACC_WIDTH'(cur_len);
        unique case (cur_base)
            BASE_HEX: acc_prod = acc_ext << 4;
            BASE_OCT: acc_prod = acc_ext << 3;
            default:  acc_prod = (acc_ext << 3) + (acc_ext << 1);
        endcase
        acc_sum = acc_prod + ACC_WIDTH'(dig.value);
        if (acc_sum[ACC_WIDTH-1:COUNT_WIDTH] != '0) begin
            acc_val = '1;
        end else begin
            acc_val = acc_sum[COUNT_WIDTH-1:0];
        end
    end

    assign is_space = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_VT_CR);

    // Parse the length number once the header name has been seen
    always_comb
    begin
        phase_next = cur_phase;
        base_next  = cur_base;
        neg_next   = cur_neg;
        len_next   = cur_len;
        if (cur_name_found) begin
            unique case (cur_phase)
                PH_COLON:
                begin
                    if (c == CHAR_COLON) phase_next = PH_SPACE;
                end
                PH_SPACE, PH_SIGN:
                begin
                    if (cur_phase == PH_SPACE && is_space) begin
                        phase_next = PH_SPACE;
                    end else if (cur_phase == PH_SPACE && c == CHAR_PLUS) begin
                        phase_next = PH_SIGN;
                    end else if (cur_phase == PH_SPACE && c == CHAR_MINUS) begin
                        neg_next   = 1'b1;
                        phase_next = PH_SIGN;
                    end else if (c == CHAR_ZERO) begin
                        base_next  = BASE_OCT;
                        len_next   = '0;
                        phase_next = PH_ZERO;
                    end else if (c >= CHAR_ONE && c <= CHAR_NINE) begin
                        base_next  = BASE_DEC;
                        len_next   = COUNT_WIDTH'(dig.value);
                        phase_next = PH_DIGITS;
                    end else begin
                        phase_next = PH_DONE;
                    end
                end
                PH_ZERO:
                begin
                    if (c == CHAR_LOW_X || c == CHAR_UP_X) begin
                        phase_next = PH_HEX;
                    end else if (dig.ok) begin
                        len_next   = COUNT_WIDTH'(dig.value);
                        phase_next = PH_DIGITS;
                    end else begin
                        phase_next = PH_DONE;
                    end
                end
                PH_HEX:
                begin
                    if (dig_hex.ok) begin
                        base_next  = BASE_HEX;
                        len_next   = COUNT_WIDTH'(dig_hex.value);
                        phase_next = PH_DIGITS;
                    end else begin
                        phase_next = PH_DONE;
                    end
                end
                PH_DIGITS:
                begin
                    if (dig.ok) begin
                        len_next = acc_val;
                    end else begin
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

    // Match the header name until it is found
    always_comb
    begin
        name_found_next = cur_name_found;
        name_prog_next  = cur_name_prog;
        name_idx        = (cur_name_prog > 4'd13) ? 4'd0 : cur_name_prog;
        if (!cur_name_found) begin
            if (c == name_char(name_idx)) begin
                name_prog_next = name_idx + 4'd1;
            end else begin
                name_prog_next = (c == CHAR_UP_C) ? 4'd1 : 4'd0;
            end
            if (name_prog_next == NAME_LEN) begin
                name_found_next = 1'b1;
                name_prog_next  = '0;
            end
        end
    end

    // Find CR LF CR LF, then count body bytes
    always_comb
    begin
        hdr_end_next  = cur_hdr_end;
        end_prog_next = cur_end_prog;
        body_next     = cur_body;
        if (cur_hdr_end) begin
            if (cur_body != '1) body_next = cur_body + COUNT_WIDTH'(1);
        end else if (c == CHAR_CR) begin
            end_prog_next = (cur_end_prog == 2'd2) ? 2'd3 : 2'd1;
        end else if (c == CHAR_LF) begin
            if (cur_end_prog == 2'd1) begin
                end_prog_next = 2'd2;
            end else if (cur_end_prog == 2'd3) begin
                hdr_end_next  = 1'b1;
                end_prog_next = 2'd0;
            end else begin
                end_prog_next = 2'd0;
            end
        end else begin
            end_prog_next = 2'd0;
        end
    end

    // Build the status beat
    always_comb
    begin
        done = hdr_end_next;
        if (hdr_end_next && name_found_next) begin
            if (neg_next && len_next != '0) begin
                done = 1'b0;
            end else if (body_next < len_next) begin
                done = 1'b0;
            end
        end
        out_beat_next.complete        = done;
        out_beat_next.headers_done    = hdr_end_next;
        out_beat_next.length_present  = name_found_next;
        out_beat_next.declared_length = FIELD_WIDTH'(len_next);
        out_beat_next.body_count      = FIELD_WIDTH'(body_next);
    end

    // Drop the valid flag once taken, raise it for each new byte
    always_comb
    begin
        if (accept) begin
            out_valid_next = 1'b1;
        end else if (status_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Hold parse state and the status register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            end_prog_reg   <= '0;
            hdr_end_reg    <= 1'b0;
            name_prog_reg  <= '0;
            name_found_reg <= 1'b0;
            phase_reg      <= PH_COLON;
            base_reg       <= BASE_DEC;
            neg_reg        <= 1'b0;
            len_reg        <= '0;
            body_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_beat_reg   <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (accept) begin
                end_prog_reg   <= end_prog_next;
                hdr_end_reg    <= hdr_end_next;
                name_prog_reg  <= name_prog_next;
                name_found_reg <= name_found_next;
                phase_reg      <= phase_next;
                base_reg       <= base_next;
                neg_reg        <= neg_next;
                len_reg        <= len_next;
                body_reg       <= body_next;
                out_beat_reg   <= out_beat_next;
            end
        end
    end

    assign status_valid = out_valid_reg;
    assign status_beat  = out_beat_reg;

endmodule

@@ rtl/hrcd_checker.sv @@
// ----------------------------------------------------------------------------
// hrcd_checker
// Port-level checks for the HTTP request completion detector.
// ----------------------------------------------------------------------------
module hrcd_checker
    import hrcd_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         byte_valid,
    input logic         byte_ready,
    input req_beat_t    byte_beat,
    input logic         status_valid,
    input logic         status_ready,
    input status_beat_t status_beat
);

    // Hold a stalled status beat
    a_status_hold: assert property (@(posedge clk) disable iff (!rst_n)
        status_valid && !status_ready |=> status_valid && $stable(status_beat))
        else $error("status beat changed while stalled");

    // Answer every accepted byte in the next cycle
    a_byte_answered: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_ready |=> status_valid)
        else $error("no status beat after accepted byte");

    // Clear all progress on the first byte of a request
    a_first_clears: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_ready && byte_beat.first_of_request |=>
        !status_beat.headers_done && !status_beat.length_present &&
        status_beat.body_count == '0)
        else $error("first byte did not start a clean request");

    // Completion needs the end of headers
    a_complete_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        status_valid && status_beat.complete |-> status_beat.headers_done)
        else $error("complete without header end");

    // Body bytes only counted after the header end
    a_body_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        status_valid && status_beat.body_count != '0 |-> status_beat.headers_done)
        else $error("body counted before header end");

endmodule

bind http_request_completion_detector hrcd_checker u_hrcd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_beat    (byte_beat),
    .status_valid (status_valid),
    .status_ready (status_ready),
    .status_beat  (status_beat)
);
